// ===== src/wbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel balance move controller package
// Shared widths, reset values, codes, the configuration bundle and the power
// saturation helper.
// ----------------------------------------------------------------------------
package wbm_pkg;

  localparam int STEP_W     = 7;
  localparam int TRIM_W     = 8;
  localparam int SCALE_W    = 24;
  localparam int AMT_W      = 16;
  localparam int CNT_W      = 16;
  localparam int PWR_W      = 8;
  localparam int TGT_W      = 20;
  localparam int MUL_A_W    = 25;
  localparam int MUL_P_W    = MUL_A_W + SCALE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [STEP_W-1:0]  POWER_STEP_RST    = 7'd5;
  localparam logic [TRIM_W-1:0]  STRAIGHT_TRIM_RST = 8'd1;
  localparam logic [TRIM_W-1:0]  ROTATE_TRIM_RST   = 8'd5;
  localparam logic [SCALE_W-1:0] COUNTS_PER_MM_RST = 24'd312908;
  localparam logic [SCALE_W-1:0] ARC_PER_DEG_RST   = 24'd51472;

  // Input operation codes; the fourth code carries no meaning.
  typedef enum logic [1:0] {
    OP_STRAIGHT = 2'd0,
    OP_ROTATE   = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_STEP    = 3'd0,
    CFG_STRAIGHT_TRIM = 3'd1,
    CFG_ROTATE_TRIM   = 3'd2,
    CFG_COUNTS_PER_MM = 3'd3,
    CFG_ARC_PER_DEG   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ARC_MUL,
    S_ARC_ADJ,
    S_CNT_MUL,
    S_TARGET,
    S_EMIT1,
    S_EMIT2
  } state_t;

  typedef struct packed {
    logic [STEP_W-1:0]  power_step;
    logic [TRIM_W-1:0]  straight_trim;
    logic [TRIM_W-1:0]  rotate_trim;
    logic [SCALE_W-1:0] counts_per_mm;
    logic [SCALE_W-1:0] arc_per_deg;
  } cfg_t;

  // Clamp a widened power value to the symmetric range -127..127.
  function automatic logic signed [PWR_W-1:0] sat127(input logic signed [9:0] p);
    logic signed [PWR_W-1:0] r;
    if (p > 10'sd127) begin
      r = 8'sd127;
    end else if (p < -10'sd127) begin
      r = -8'sd127;
    end else begin
      r = p[PWR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/wbm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the step, trim and Q16 scale registers; writes to unused indexes are
// dropped.
// ----------------------------------------------------------------------------
module wbm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [wbm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [wbm_pkg::CFG_DATA_W-1:0]   wr_data,
  output wbm_pkg::cfg_t                    cfg
);

  wbm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_step    <= wbm_pkg::POWER_STEP_RST;
      cfg_r.straight_trim <= wbm_pkg::STRAIGHT_TRIM_RST;
      cfg_r.rotate_trim   <= wbm_pkg::ROTATE_TRIM_RST;
      cfg_r.counts_per_mm <= wbm_pkg::COUNTS_PER_MM_RST;
      cfg_r.arc_per_deg   <= wbm_pkg::ARC_PER_DEG_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        wbm_pkg::CFG_POWER_STEP:    cfg_r.power_step    <= wr_data[wbm_pkg::STEP_W-1:0];
        wbm_pkg::CFG_STRAIGHT_TRIM: cfg_r.straight_trim <= wr_data[wbm_pkg::TRIM_W-1:0];
        wbm_pkg::CFG_ROTATE_TRIM:   cfg_r.rotate_trim   <= wr_data[wbm_pkg::TRIM_W-1:0];
        wbm_pkg::CFG_COUNTS_PER_MM: cfg_r.counts_per_mm <= wr_data[wbm_pkg::SCALE_W-1:0];
        wbm_pkg::CFG_ARC_PER_DEG:   cfg_r.arc_per_deg   <= wr_data[wbm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/wbm_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 25 x 24 multiply with a registered product, used for both the arc
// scaling and the count scaling of a start.
// ----------------------------------------------------------------------------
module wbm_mult (
  input  logic                           clk,
  input  logic [wbm_pkg::MUL_A_W-1:0]    a,
  input  logic [wbm_pkg::SCALE_W-1:0]    b,
  output logic [wbm_pkg::MUL_P_W-1:0]    prod
);

  logic [wbm_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// ===== src/wheel_balance_move_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel balance move controller
// Starts straight moves and in-place rotations, converts the requested amount
// into a target encoder count, and balances the two motor powers on each tick.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Beat contents
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall  | op, amount, speed, left/right count
//  out_    | output    | out_valid/out_stall| left/right power, moving, last
//  cfg_    | input     | cfg_valid/cfg_ready| register index and write data
//
//  A tick is captured, then decoded and applied to the move state, and its first
//  result beat is then loaded into the output register.
//  A straight start passes once through the single shared multiplier (count
//  scaling) and a rotation start twice (arc scaling, then count scaling).
//  A second result beat, when one follows, is sent from S_EMIT2 after the first.
//  in_stall is high during reset and whenever the sequencer is busy; a stalled
//  output register simply holds the sequencer in its emit state. cfg_ready is
//  high whenever reset is released.
//  Reset is synchronous and active low; it clears the move state and restores
//  the register defaults.
// ----------------------------------------------------------------------------
module wheel_balance_move_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [wbm_pkg::AMT_W-1:0]         in_amount,
  input  logic signed [wbm_pkg::PWR_W-1:0]  in_speed,
  input  logic signed [wbm_pkg::CNT_W-1:0]  in_left_count,
  input  logic signed [wbm_pkg::CNT_W-1:0]  in_right_count,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [wbm_pkg::PWR_W-1:0]  out_left_power,
  output logic signed [wbm_pkg::PWR_W-1:0]  out_right_power,
  output logic                              out_moving,
  output logic                              out_last,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Two's-complement magnitude of a signed millimeter value.
  function automatic logic [wbm_pkg::MUL_A_W-1:0] mag_of(input logic [25:0] v);
    logic [25:0] n;
    n = v[25] ? (26'd0 - v) : v;
    return n[wbm_pkg::MUL_A_W-1:0];
  endfunction

  wbm_pkg::cfg_t   cfg;
  wbm_pkg::state_t state_r, state_nxt;

  // Captured input beat.
  logic [1:0]                        op_r;
  logic [wbm_pkg::AMT_W-1:0]         amount_r;
  logic signed [wbm_pkg::PWR_W-1:0]  speed_r;
  logic signed [wbm_pkg::CNT_W-1:0]  lc_r, rc_r;

  // Move state.
  logic                              active_r, active_nxt;
  logic                              rotating_r, rotating_nxt;
  logic                              reverse_r, reverse_nxt;
  logic signed [wbm_pkg::PWR_W-1:0]  left_cmd_r, left_cmd_nxt;
  logic signed [wbm_pkg::PWR_W-1:0]  right_cmd_r, right_cmd_nxt;
  logic signed [wbm_pkg::CNT_W-1:0]  prev_left_r, prev_left_nxt;
  logic signed [wbm_pkg::CNT_W-1:0]  prev_right_r, prev_right_nxt;
  logic [wbm_pkg::TGT_W-1:0]         target_r, target_nxt;
  logic [wbm_pkg::MUL_A_W-1:0]       mag_r, mag_nxt;

  // Pending first result and whether a closing beat follows it.
  logic signed [wbm_pkg::PWR_W-1:0]  res_left_r, res_left_nxt;
  logic signed [wbm_pkg::PWR_W-1:0]  res_right_r, res_right_nxt;
  logic                              res_moving_r, res_moving_nxt;
  logic                              res_last_r, res_last_nxt;
  logic                              two_r, two_nxt;

  // Output register.
  logic                              out_valid_r, out_valid_nxt;
  logic signed [wbm_pkg::PWR_W-1:0]  out_left_r, out_left_nxt;
  logic signed [wbm_pkg::PWR_W-1:0]  out_right_r, out_right_nxt;
  logic                              out_moving_r, out_moving_nxt;
  logic                              out_last_r, out_last_nxt;

  // Shared multiplier.
  logic [wbm_pkg::MUL_A_W-1:0]       mul_a;
  logic [wbm_pkg::SCALE_W-1:0]       mul_b;
  logic [wbm_pkg::MUL_P_W-1:0]       mul_p;

  // Datapath terms.
  logic                              in_take, out_free, start_zero;
  logic [9:0]                        spd_ext, spd_neg;
  logic signed [wbm_pkg::PWR_W-1:0]  start_left, start_right;
  logic [25:0]                       straight_mm, rotate_mm;
  logic [wbm_pkg::SCALE_W-1:0]       arc_mm;
  logic [wbm_pkg::MUL_P_W:0]         rounded;
  logic [33:0]                       target_full;
  logic [wbm_pkg::TGT_W-1:0]         target_sat;
  logic [16:0]                       ldiff, rdiff, labs, rabs, rmag;
  logic [9:0]                        step_ext, delta, left_sum, right_sum;
  logic                              flip, wheels_equal, reached;
  logic signed [wbm_pkg::PWR_W-1:0]  tick_left, tick_right;

  wbm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The multiplier scales degrees into arc mm in a rotation's first pass and mm into
  // counts in the last pass of every start.
  assign mul_a = (state_r == wbm_pkg::S_ARC_MUL)
               ? {{(wbm_pkg::MUL_A_W - wbm_pkg::AMT_W){1'b0}}, amount_r} : mag_r;
  assign mul_b = (state_r == wbm_pkg::S_ARC_MUL) ? cfg.arc_per_deg : cfg.counts_per_mm;

  wbm_mult u_mult (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  assign cfg_ready = rst_n;
  assign in_stall  = !rst_n || (state_r != wbm_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Start terms. A speed of -128 saturates to -127, and its negation to 127.
  assign start_zero  = (amount_r == '0) || (speed_r == '0);
  assign spd_ext     = {{2{speed_r[7]}}, speed_r};
  assign spd_neg     = 10'd0 - spd_ext;
  assign start_left  = wbm_pkg::sat127(spd_ext);
  assign start_right = wbm_pkg::sat127((op_r == wbm_pkg::OP_ROTATE) ? spd_neg : spd_ext);

  // Trim shortens a forward move and lengthens a reverse one.
  assign straight_mm = speed_r[7]
                     ? ({10'd0, amount_r} + {18'd0, cfg.straight_trim})
                     : ({10'd0, amount_r} - {18'd0, cfg.straight_trim});
  assign arc_mm      = mul_p[16 +: wbm_pkg::SCALE_W];
  assign rotate_mm   = reverse_r
                     ? ({2'd0, arc_mm} + {18'd0, cfg.rotate_trim})
                     : ({2'd0, arc_mm} - {18'd0, cfg.rotate_trim});

  // Ceiling of the Q16 product, saturated to the target width.
  assign rounded     = {1'b0, mul_p} + (wbm_pkg::MUL_P_W + 1)'(16'hFFFF);
  assign target_full = rounded[wbm_pkg::MUL_P_W:16];
  assign target_sat  = (target_full[33:wbm_pkg::TGT_W] != '0) ? '1
                                                              : target_full[wbm_pkg::TGT_W-1:0];

  // Tick terms: wheel advances are compared as 17-bit magnitudes.
  assign ldiff = {lc_r[15], lc_r} - {prev_left_r[15], prev_left_r};
  assign rdiff = {rc_r[15], rc_r} - {prev_right_r[15], prev_right_r};
  assign labs  = ldiff[16] ? (17'd0 - ldiff) : ldiff;
  assign rabs  = rdiff[16] ? (17'd0 - rdiff) : rdiff;
  assign rmag  = rc_r[15] ? (17'd0 - {rc_r[15], rc_r}) : {1'b0, rc_r};

  assign wheels_equal = (labs == rabs);
  assign flip         = reverse_r ^ (labs < rabs);
  assign step_ext     = {3'd0, cfg.power_step};
  assign delta        = flip ? (10'd0 - step_ext) : step_ext;
  assign left_sum     = {{2{left_cmd_r[7]}}, left_cmd_r} - delta;
  assign right_sum    = rotating_r ? ({{2{right_cmd_r[7]}}, right_cmd_r} - delta)
                                   : ({{2{right_cmd_r[7]}}, right_cmd_r} + delta);
  assign tick_left    = wheels_equal ? left_cmd_r  : wbm_pkg::sat127(left_sum);
  assign tick_right   = wheels_equal ? right_cmd_r : wbm_pkg::sat127(right_sum);
  assign reached      = ({3'd0, rmag} >= target_r);

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    rotating_nxt   = rotating_r;
    reverse_nxt    = reverse_r;
    left_cmd_nxt   = left_cmd_r;
    right_cmd_nxt  = right_cmd_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    target_nxt     = target_r;
    mag_nxt        = mag_r;
    res_left_nxt   = res_left_r;
    res_right_nxt  = res_right_r;
    res_moving_nxt = res_moving_r;
    res_last_nxt   = res_last_r;
    two_nxt        = two_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_moving_nxt = out_moving_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      wbm_pkg::S_IDLE: begin
        if (in_take) begin
          state_nxt = wbm_pkg::S_DECODE;
        end
      end

      wbm_pkg::S_DECODE: begin
        unique case (op_r) inside
          wbm_pkg::OP_STRAIGHT, wbm_pkg::OP_ROTATE: begin
            active_nxt     = 1'b0;
            prev_left_nxt  = '0;
            prev_right_nxt = '0;
            left_cmd_nxt   = '0;
            right_cmd_nxt  = '0;
            if (start_zero) begin
              res_left_nxt   = '0;
              res_right_nxt  = '0;
              res_moving_nxt = 1'b0;
              res_last_nxt   = 1'b1;
              two_nxt        = 1'b0;
              state_nxt      = wbm_pkg::S_EMIT1;
            end else begin
              rotating_nxt  = (op_r == wbm_pkg::OP_ROTATE);
              reverse_nxt   = speed_r[7];
              left_cmd_nxt  = start_left;
              right_cmd_nxt = start_right;
              if (op_r == wbm_pkg::OP_ROTATE) begin
                state_nxt = wbm_pkg::S_ARC_MUL;
              end else begin
                mag_nxt   = mag_of(straight_mm);
                state_nxt = wbm_pkg::S_CNT_MUL;
              end
            end
          end
          wbm_pkg::OP_TICK: begin
            state_nxt = wbm_pkg::S_EMIT1;
            if (!active_r) begin
              res_left_nxt   = '0;
              res_right_nxt  = '0;
              res_moving_nxt = 1'b0;
              res_last_nxt   = 1'b1;
              two_nxt        = 1'b0;
            end else begin
              prev_left_nxt  = lc_r;
              prev_right_nxt = rc_r;
              res_left_nxt   = tick_left;
              res_right_nxt  = tick_right;
              res_moving_nxt = 1'b1;
              if (reached) begin
                // Target met: report the last powers, then a stop beat.
                res_last_nxt  = 1'b0;
                two_nxt       = 1'b1;
                active_nxt    = 1'b0;
                left_cmd_nxt  = '0;
                right_cmd_nxt = '0;
              end else begin
                res_last_nxt  = 1'b1;
                two_nxt       = 1'b0;
                left_cmd_nxt  = tick_left;
                right_cmd_nxt = tick_right;
              end
            end
          end
          default: begin
            state_nxt = wbm_pkg::S_IDLE;
          end
        endcase
      end

      wbm_pkg::S_ARC_MUL: begin
        state_nxt = wbm_pkg::S_ARC_ADJ;
      end

      wbm_pkg::S_ARC_ADJ: begin
        mag_nxt   = mag_of(rotate_mm);
        state_nxt = wbm_pkg::S_CNT_MUL;
      end

      wbm_pkg::S_CNT_MUL: begin
        state_nxt = wbm_pkg::S_TARGET;
      end

      wbm_pkg::S_TARGET: begin
        target_nxt     = target_sat;
        res_left_nxt   = left_cmd_r;
        res_right_nxt  = right_cmd_r;
        res_moving_nxt = 1'b1;
        state_nxt      = wbm_pkg::S_EMIT1;
        if (target_sat == '0) begin
          // Nothing to travel: the start beat is followed by a stop beat.
          res_last_nxt  = 1'b0;
          two_nxt       = 1'b1;
          left_cmd_nxt  = '0;
          right_cmd_nxt = '0;
        end else begin
          res_last_nxt = 1'b1;
          two_nxt      = 1'b0;
          active_nxt   = 1'b1;
        end
      end

      wbm_pkg::S_EMIT1: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_left_nxt   = res_left_r;
          out_right_nxt  = res_right_r;
          out_moving_nxt = res_moving_r;
          out_last_nxt   = res_last_r;
          state_nxt      = two_r ? wbm_pkg::S_EMIT2 : wbm_pkg::S_IDLE;
        end
      end

      wbm_pkg::S_EMIT2: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_left_nxt   = '0;
          out_right_nxt  = '0;
          out_moving_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = wbm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = wbm_pkg::S_IDLE;
      end
    endcase
  end

  // Control and move state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wbm_pkg::S_IDLE;
      active_r     <= 1'b0;
      rotating_r   <= 1'b0;
      reverse_r    <= 1'b0;
      left_cmd_r   <= '0;
      right_cmd_r  <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      target_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      rotating_r   <= rotating_nxt;
      reverse_r    <= reverse_nxt;
      left_cmd_r   <= left_cmd_nxt;
      right_cmd_r  <= right_cmd_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      target_r     <= target_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_op;
      amount_r <= in_amount;
      speed_r  <= in_speed;
      lc_r     <= in_left_count;
      rc_r     <= in_right_count;
    end
    mag_r        <= mag_nxt;
    res_left_r   <= res_left_nxt;
    res_right_r  <= res_right_nxt;
    res_moving_r <= res_moving_nxt;
    res_last_r   <= res_last_nxt;
    two_r        <= two_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
    out_moving_r <= out_moving_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_left_power  = out_left_r;
  assign out_right_power = out_right_r;
  assign out_moving      = out_moving_r;
  assign out_last        = out_last_r;

endmodule

// ===== tb/tb_wheel_balance_move_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel balance move controller testbench
// Drives start and tick beats with random handshake gaps. A behavioral model
// predicts the beats that the directed table does not type in; every result beat
// is checked in order. Five register settings are covered, the extremes among them.
// ----------------------------------------------------------------------------
module tb_wheel_balance_move_controller_top;

  // Timing and run limits.
  localparam int RESET_CYCLES  = 9;
  localparam int HOLD_CYCLES   = 300;   // one long receiver hold-off
  localparam int SETTLE_CYCLES = 12;    // covers the slowest start plus a second beat
  localparam int QUIET_LIMIT   = 5000;  // cycles with no beat on any channel
  localparam int REPORT_MAX    = 10;

  // The fourth op code is not decoded; the block drops such beats.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam longint     TARGET_SAT = (longint'(1) << wbm_pkg::TGT_W) - 1;

  typedef struct {
    logic signed [wbm_pkg::PWR_W-1:0] left;
    logic signed [wbm_pkg::PWR_W-1:0] right;
    logic                             moving;
    logic                             last;
  } motor_cmd_t;

  // One row of the directed table. Rows with typed set carry their own
  // expected beat (or none, when yields is clear); the others are predicted.
  typedef struct {
    logic [1:0]                       op;
    logic [wbm_pkg::AMT_W-1:0]        amount;
    logic signed [wbm_pkg::PWR_W-1:0] speed;
    logic signed [wbm_pkg::CNT_W-1:0] lcnt;
    logic signed [wbm_pkg::CNT_W-1:0] rcnt;
    bit                               typed;
    bit                               yields;
    motor_cmd_t                       cmd;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       in_op;
  logic [wbm_pkg::AMT_W-1:0]        in_amount;
  logic signed [wbm_pkg::PWR_W-1:0] in_speed;
  logic signed [wbm_pkg::CNT_W-1:0] in_left_count;
  logic signed [wbm_pkg::CNT_W-1:0] in_right_count;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [wbm_pkg::PWR_W-1:0] out_left_power;
  logic signed [wbm_pkg::PWR_W-1:0] out_right_power;
  logic                             out_moving;
  logic                             out_last;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [wbm_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [wbm_pkg::CFG_DATA_W-1:0]   cfg_data;

  wheel_balance_move_controller_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_amount       (in_amount),
    .in_speed        (in_speed),
    .in_left_count   (in_left_count),
    .in_right_count  (in_right_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_power  (out_left_power),
    .out_right_power (out_right_power),
    .out_moving      (out_moving),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 12 ns clock period.
  always #6 clk = ~clk;

  // Shadow copy of the move state and the registers. It is advanced at the
  // rising edge on which a beat is accepted, well ahead of the result beat.
  bit                               mv_active;
  bit                               mv_rotating;
  bit                               mv_reverse;
  logic signed [wbm_pkg::PWR_W-1:0] cmd_left;
  logic signed [wbm_pkg::PWR_W-1:0] cmd_right;
  logic signed [wbm_pkg::CNT_W-1:0] last_left_cnt;
  logic signed [wbm_pkg::CNT_W-1:0] last_right_cnt;
  logic [wbm_pkg::TGT_W-1:0]        target_cnt;
  logic [wbm_pkg::STEP_W-1:0]       k_step;
  logic [wbm_pkg::TRIM_W-1:0]       k_strim;
  logic [wbm_pkg::TRIM_W-1:0]       k_rtrim;
  logic [wbm_pkg::SCALE_W-1:0]      k_cpm;
  logic [wbm_pkg::SCALE_W-1:0]      k_apd;

  // Power command beats still owed by the block, oldest first.
  motor_cmd_t pending_cmds[$];
  stim_row_t  directed_rows[$];
  motor_cmd_t due_cmd;

  int  beats_in;
  int  results_seen;
  int  settings_used;
  int  mismatches;
  int  quiet_cycles;
  int  hold_asked;
  int  hold_seen;
  int  stall_left;
  int  stall_pick;
  bit  calm;

  function automatic logic signed [wbm_pkg::PWR_W-1:0] clamp_power(int p);
    if (p > 127) begin
      return 8'sd127;
    end
    if (p < -127) begin
      return -8'sd127;
    end
    return p[wbm_pkg::PWR_W-1:0];
  endfunction

  function automatic void queue_cmd(int l, int r, bit mv, bit la, bit keep);
    motor_cmd_t c;
    c.left   = l[wbm_pkg::PWR_W-1:0];
    c.right  = r[wbm_pkg::PWR_W-1:0];
    c.moving = mv;
    c.last   = la;
    if (keep) begin
      pending_cmds.push_back(c);
    end
  endfunction

  function automatic void reset_model();
    mv_active      = 1'b0;
    mv_rotating    = 1'b0;
    mv_reverse     = 1'b0;
    cmd_left       = '0;
    cmd_right      = '0;
    last_left_cnt  = '0;
    last_right_cnt = '0;
    target_cnt     = '0;
    k_step         = 7'd5;
    k_strim        = 8'd1;
    k_rtrim        = 8'd5;
    k_cpm          = 24'd312908;
    k_apd          = 24'd51472;
  endfunction

  function automatic void apply_reg(logic [wbm_pkg::CFG_IDX_W-1:0] idx,
                                    logic [wbm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      wbm_pkg::CFG_POWER_STEP:    k_step  = data[wbm_pkg::STEP_W-1:0];
      wbm_pkg::CFG_STRAIGHT_TRIM: k_strim = data[wbm_pkg::TRIM_W-1:0];
      wbm_pkg::CFG_ROTATE_TRIM:   k_rtrim = data[wbm_pkg::TRIM_W-1:0];
      wbm_pkg::CFG_COUNTS_PER_MM: k_cpm   = data[wbm_pkg::SCALE_W-1:0];
      wbm_pkg::CFG_ARC_PER_DEG:   k_apd   = data[wbm_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the power command beats caused by one accepted beat and
  // queues them when keep is set.
  function automatic void predict_motor_cmds(logic [1:0] op,
                                             logic [wbm_pkg::AMT_W-1:0] amount,
                                             logic signed [wbm_pkg::PWR_W-1:0] speed,
                                             logic signed [wbm_pkg::CNT_W-1:0] lcnt,
                                             logic signed [wbm_pkg::CNT_W-1:0] rcnt,
                                             bit keep);
    int     sp;
    int     ld;
    int     rd;
    int     d;
    int     rmag;
    longint mm;
    longint mag;
    longint t;
    sp = speed;
    if (op == wbm_pkg::OP_STRAIGHT || op == wbm_pkg::OP_ROTATE) begin
      // Any start ends the current move first.
      mv_active      = 1'b0;
      last_left_cnt  = '0;
      last_right_cnt = '0;
      cmd_left       = '0;
      cmd_right      = '0;
      if (amount == '0 || sp == 0) begin
        queue_cmd(0, 0, 1'b0, 1'b1, keep);
        return;
      end
      mv_rotating = (op == wbm_pkg::OP_ROTATE);
      mv_reverse  = (sp < 0);
      if (mv_rotating) begin
        mm = (longint'(amount) * longint'(k_apd)) >>> 16;
        mm += mv_reverse ? longint'(k_rtrim) : -longint'(k_rtrim);
      end else begin
        mm = longint'(amount);
        mm += mv_reverse ? longint'(k_strim) : -longint'(k_strim);
      end
      mag = (mm < 0) ? -mm : mm;
      t = (mag * longint'(k_cpm) + 65535) >>> 16;
      target_cnt = (t > TARGET_SAT) ? TARGET_SAT[wbm_pkg::TGT_W-1:0]
                                    : t[wbm_pkg::TGT_W-1:0];
      cmd_left  = clamp_power(sp);
      cmd_right = clamp_power(mv_rotating ? -sp : sp);
      if (target_cnt == '0) begin
        // Nothing to travel: the start beat is followed by a stop beat.
        queue_cmd(cmd_left, cmd_right, 1'b1, 1'b0, keep);
        cmd_left  = '0;
        cmd_right = '0;
        queue_cmd(0, 0, 1'b0, 1'b1, keep);
        return;
      end
      mv_active = 1'b1;
      queue_cmd(cmd_left, cmd_right, 1'b1, 1'b1, keep);
    end else if (op == wbm_pkg::OP_TICK) begin
      if (!mv_active) begin
        queue_cmd(0, 0, 1'b0, 1'b1, keep);
        return;
      end
      ld = int'(lcnt) - int'(last_left_cnt);
      rd = int'(rcnt) - int'(last_right_cnt);
      if (ld < 0) ld = -ld;
      if (rd < 0) rd = -rd;
      last_left_cnt  = lcnt;
      last_right_cnt = rcnt;
      d = k_step;
      if (mv_reverse) d = -d;
      if (ld != rd) begin
        if (ld < rd) d = -d;
        cmd_left  = clamp_power(cmd_left - d);
        cmd_right = clamp_power(mv_rotating ? cmd_right - d : cmd_right + d);
      end
      rmag = rcnt;
      if (rmag < 0) rmag = -rmag;
      if (rmag >= int'(target_cnt)) begin
        queue_cmd(cmd_left, cmd_right, 1'b1, 1'b0, keep);
        mv_active = 1'b0;
        cmd_left  = '0;
        cmd_right = '0;
        queue_cmd(0, 0, 1'b0, 1'b1, keep);
        return;
      end
      queue_cmd(cmd_left, cmd_right, 1'b1, 1'b1, keep);
    end
  endfunction

  // Directed table rows: one whose beats come from the model, one typed in.
  task automatic row_checked(logic [1:0] op, logic [wbm_pkg::AMT_W-1:0] amount,
                             logic signed [wbm_pkg::PWR_W-1:0] speed,
                             logic signed [wbm_pkg::CNT_W-1:0] lcnt,
                             logic signed [wbm_pkg::CNT_W-1:0] rcnt);
    stim_row_t row;
    row.op     = op;
    row.amount = amount;
    row.speed  = speed;
    row.lcnt   = lcnt;
    row.rcnt   = rcnt;
    row.typed  = 1'b0;
    row.yields = 1'b0;
    row.cmd    = '{default: '0};
    directed_rows.push_back(row);
  endtask

  task automatic row_typed(logic [1:0] op, logic [wbm_pkg::AMT_W-1:0] amount,
                           logic signed [wbm_pkg::PWR_W-1:0] speed,
                           logic signed [wbm_pkg::CNT_W-1:0] lcnt,
                           logic signed [wbm_pkg::CNT_W-1:0] rcnt,
                           bit yields, int l, int r, bit mv, bit la);
    stim_row_t row;
    row.op         = op;
    row.amount     = amount;
    row.speed      = speed;
    row.lcnt       = lcnt;
    row.rcnt       = rcnt;
    row.typed      = 1'b1;
    row.yields     = yields;
    row.cmd.left   = l[wbm_pkg::PWR_W-1:0];
    row.cmd.right  = r[wbm_pkg::PWR_W-1:0];
    row.cmd.moving = mv;
    row.cmd.last   = la;
    directed_rows.push_back(row);
  endtask

  // Offers one beat from the falling edge and holds it until accepted.
  task automatic send_beat(logic [1:0] op, logic [wbm_pkg::AMT_W-1:0] amount,
                           logic signed [wbm_pkg::PWR_W-1:0] speed,
                           logic signed [wbm_pkg::CNT_W-1:0] lcnt,
                           logic signed [wbm_pkg::CNT_W-1:0] rcnt,
                           bit predicted);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_amount      <= amount;
    in_speed       <= speed;
    in_left_count  <= lcnt;
    in_right_count <= rcnt;
    do @(posedge clk); while (in_stall);
    predict_motor_cmds(op, amount, speed, lcnt, rcnt, predicted);
    if (op != OP_UNUSED) beats_in++;
  endtask

  // Sender gap: usually none, sometimes short, now and then a long one.
  task automatic idle_sender();
    int pick;
    int n;
    if (calm) return;
    pick = $urandom_range(0, 99);
    if (pick < 75) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stops offering beats and waits until every owed result has arrived.
  task automatic wait_drained(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Register write with random junk above the register's width.
  task automatic write_reg(logic [wbm_pkg::CFG_IDX_W-1:0] idx, int value, int width);
    logic [wbm_pkg::CFG_DATA_W-1:0] mask;
    logic [wbm_pkg::CFG_DATA_W-1:0] data;
    mask = (wbm_pkg::CFG_DATA_W'(1) << width) - 1'b1;
    data = wbm_pkg::CFG_DATA_W'($urandom);
    data = (data & ~mask) | (wbm_pkg::CFG_DATA_W'(value) & mask);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic load_settings(int step, int strim, int rtrim, int cpm, int apd);
    wait_drained(SETTLE_CYCLES);
    write_reg(wbm_pkg::CFG_POWER_STEP, step, wbm_pkg::STEP_W);
    write_reg(wbm_pkg::CFG_STRAIGHT_TRIM, strim, wbm_pkg::TRIM_W);
    write_reg(wbm_pkg::CFG_ROTATE_TRIM, rtrim, wbm_pkg::TRIM_W);
    write_reg(wbm_pkg::CFG_COUNTS_PER_MM, cpm, wbm_pkg::SCALE_W);
    write_reg(wbm_pkg::CFG_ARC_PER_DEG, apd, wbm_pkg::SCALE_W);
    // An index past the last register must leave every register alone.
    write_reg(wbm_pkg::CFG_IDX_W'($urandom_range(int'(wbm_pkg::CFG_ARC_PER_DEG) + 1,
                                                 (1 << wbm_pkg::CFG_IDX_W) - 1)),
              $urandom, wbm_pkg::CFG_DATA_W);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One move: a start, then ticks whose encoder counts advance the way the
  // wheels would turn, with some noise mixed in, until the target is reached
  // or the move is cut short by the next start.
  task automatic drive_move();
    logic [1:0]                       op;
    logic [wbm_pkg::AMT_W-1:0]        amount;
    logic signed [wbm_pkg::PWR_W-1:0] speed;
    logic signed [wbm_pkg::CNT_W-1:0] lc;
    logic signed [wbm_pkg::CNT_W-1:0] rc;
    int                               ldir;
    int                               rdir;
    int                               n;
    int                               stp;
    int                               wob;
    int                               pick;
    op = $urandom_range(0, 1) ? wbm_pkg::OP_ROTATE : wbm_pkg::OP_STRAIGHT;
    if ($urandom_range(0, 99) < 85) begin
      amount = (op == wbm_pkg::OP_ROTATE) ? wbm_pkg::AMT_W'($urandom_range(0, 400))
                                          : wbm_pkg::AMT_W'($urandom_range(0, 250));
    end else begin
      amount = wbm_pkg::AMT_W'($urandom);
    end
    speed = ($urandom_range(0, 99) < 5) ? 8'sd0 : wbm_pkg::PWR_W'($urandom);
    send_beat(op, amount, speed, wbm_pkg::CNT_W'($urandom), wbm_pkg::CNT_W'($urandom), 1'b1);
    idle_sender();
    ldir = (speed < 0) ? -1 : 1;
    rdir = (op == wbm_pkg::OP_ROTATE) ? -ldir : ldir;
    lc = '0;
    rc = '0;
    n = $urandom_range(1, 60);
    repeat (n) begin
      if (!mv_active) break;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_beat(OP_UNUSED, wbm_pkg::AMT_W'($urandom), wbm_pkg::PWR_W'($urandom),
                  wbm_pkg::CNT_W'($urandom), wbm_pkg::CNT_W'($urandom), 1'b1);
      end else if (pick < 6) begin
        send_beat(wbm_pkg::OP_TICK, wbm_pkg::AMT_W'($urandom), wbm_pkg::PWR_W'($urandom),
                  wbm_pkg::CNT_W'($urandom), wbm_pkg::CNT_W'($urandom), 1'b1);
      end else if (pick < 8) begin
        // Leave the move running; the next start replaces it.
        return;
      end else begin
        stp = $urandom_range(0, 45);
        wob = stp + $urandom_range(0, 8) - 4;
        if (wob < 0) wob = 0;
        lc = lc + wbm_pkg::CNT_W'(ldir * wob);
        rc = rc + wbm_pkg::CNT_W'(rdir * stp);
        send_beat(wbm_pkg::OP_TICK, wbm_pkg::AMT_W'($urandom), wbm_pkg::PWR_W'($urandom),
                  lc, rc, 1'b1);
      end
      idle_sender();
    end
    if ($urandom_range(0, 99) < 30) begin
      send_beat(wbm_pkg::OP_TICK, wbm_pkg::AMT_W'($urandom), wbm_pkg::PWR_W'($urandom),
                lc, rc, 1'b1);
      idle_sender();
    end
  endtask

  // A phase of random moves. The first fifth runs without any idling; when
  // press is set the receiver holds off for a long stretch halfway through
  // while moves keep coming, and later the sender waits for a full drain.
  task automatic random_phase(int n, bit press);
    int  first;
    bit  pressed;
    bit  paused;
    first   = beats_in;
    pressed = 1'b0;
    paused  = 1'b0;
    calm    = 1'b1;
    while (beats_in < first + n) begin
      if (beats_in >= first + n / 5) calm = 1'b0;
      if (press && !pressed && beats_in >= first + n / 2) begin
        hold_asked++;
        pressed = 1'b1;
      end
      if (press && !paused && beats_in >= first + (3 * n) / 4) begin
        wait_drained(0);
        paused = 1'b1;
      end
      drive_move();
    end
    calm = 1'b0;
  endtask

  // Receiver: sets out_stall at each falling edge. A requested hold-off is
  // counted down here; otherwise stalls are mostly short with a rare long one.
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen  = hold_asked;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        out_stall <= 1'b0;
      end else if (stall_pick < 96) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(15, 50);
      end
    end
  end

  // Result checker: each accepted result beat is matched against the oldest
  // owed command; a beat with nothing owed is a failure too.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_cmds.size() == 0) begin
        if (mismatches < REPORT_MAX) begin
          $display("Unexpected result beat: L=%0d R=%0d moving=%0b last=%0b",
                   out_left_power, out_right_power, out_moving, out_last);
        end
        mismatches++;
      end else begin
        due_cmd = pending_cmds.pop_front();
        if (out_left_power !== due_cmd.left || out_right_power !== due_cmd.right ||
            out_moving !== due_cmd.moving || out_last !== due_cmd.last) begin
          if (mismatches < REPORT_MAX) begin
            $display({"Result beat %0d: expected L=%0d R=%0d moving=%0b last=%0b, ",
                      "got L=%0d R=%0d moving=%0b last=%0b"},
                     results_seen, due_cmd.left, due_cmd.right, due_cmd.moving,
                     due_cmd.last, out_left_power, out_right_power, out_moving, out_last);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles, %0d results still owed",
                 QUIET_LIMIT, pending_cmds.size());
        $display("wheel_balance_move_controller_top test failed");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = wbm_pkg::OP_TICK;
    in_amount      = '0;
    in_speed       = '0;
    in_left_count  = '0;
    in_right_count = '0;
    cfg_valid      = 1'b0;
    cfg_index      = wbm_pkg::CFG_POWER_STEP;
    cfg_data       = '0;
    calm           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset register values.
    // A tick with no move running just reports zero power.
    row_typed(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd0, 16'sd0, 1'b1, 0, 0, 1'b0, 1'b1);
    // The unused op code produces nothing.
    row_typed(OP_UNUSED, 16'd0, 8'sd0, 16'sd0, 16'sd0, 1'b0, 0, 0, 1'b0, 1'b0);
    // Zero amount or zero speed stops at once.
    row_typed(wbm_pkg::OP_STRAIGHT, 16'd0, 8'sd50, 16'sd0, 16'sd0, 1'b1, 0, 0, 1'b0, 1'b1);
    row_typed(wbm_pkg::OP_ROTATE, 16'd90, 8'sd0, 16'sd0, 16'sd0, 1'b1, 0, 0, 1'b0, 1'b1);
    // Full forward speed, then equal, left-faster and right-faster ticks.
    row_typed(wbm_pkg::OP_STRAIGHT, 16'd100, 8'sd127, 16'sd0, 16'sd0, 1'b1,
              127, 127, 1'b1, 1'b1);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd10, 16'sd10);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd25, 16'sd20);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd30, 16'sd40);
    // The trim eats the whole distance, so the start is followed by a stop.
    row_checked(wbm_pkg::OP_STRAIGHT, 16'd1, 8'sd40, 16'sd0, 16'sd0);
    // The most negative speed acts as -127; reverse ticks then saturate.
    row_typed(wbm_pkg::OP_STRAIGHT, 16'd200, -8'sd128, 16'sd0, 16'sd0, 1'b1,
              -127, -127, 1'b1, 1'b1);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, -16'sd10, -16'sd5);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, -16'sd12, -16'sd15);
    // A reverse rotation replaces the running move.
    row_typed(wbm_pkg::OP_ROTATE, 16'd90, -8'sd128, 16'sd0, 16'sd0, 1'b1,
              -127, 127, 1'b1, 1'b1);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, -16'sd30, 16'sd30);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, -16'sd40, 16'sd60);
    // Extreme counts reach the target and end the move.
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, -16'sd32768, 16'sd32767);
    row_typed(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd0, 16'sd0, 1'b1, 0, 0, 1'b0, 1'b1);
    // Largest amounts in both modes, with the counts at the opposite extremes.
    row_typed(wbm_pkg::OP_ROTATE, 16'hFFFF, 8'sd127, 16'sd0, 16'sd0, 1'b1,
              127, -127, 1'b1, 1'b1);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd32767, -16'sd32768);
    row_checked(wbm_pkg::OP_STRAIGHT, 16'hFFFF, 8'sd1, 16'sd0, 16'sd0);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd0, 16'sd0);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd7, 16'sd0);
    // A one-degree rotation whose arc is smaller than the trim.
    row_checked(wbm_pkg::OP_ROTATE, 16'd1, 8'sd64, 16'sd0, 16'sd0);
    row_checked(wbm_pkg::OP_TICK, 16'd0, 8'sd0, 16'sd3, -16'sd24);
    row_typed(OP_UNUSED, 16'hFFFF, -8'sd1, -16'sd1, -16'sd1, 1'b0, 0, 0, 1'b0, 1'b0);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].amount, directed_rows[i].speed,
                directed_rows[i].lcnt, directed_rows[i].rcnt, !directed_rows[i].typed);
      if (directed_rows[i].typed && directed_rows[i].yields) begin
        pending_cmds.push_back(directed_rows[i].cmd);
      end
      idle_sender();
    end

    // Random moves at the reset values, with receiver and sender pressure.
    random_phase(150, 1'b1);
    // Largest step, no trims, one count per mm and one mm per degree.
    load_settings(127, 0, 0, 65536, 65536);
    random_phase(130, 1'b0);
    // Zero step, largest trims and scales, so big targets saturate.
    load_settings(0, 255, 255, 24'hFFFFFF, 24'hFFFFFF);
    random_phase(60, 1'b1);
    // Zero counts per mm: every start ends at once.
    load_settings(1, $urandom_range(0, 255), $urandom_range(0, 255), 0,
                  $urandom_range(0, 24'hFFFFFF));
    random_phase(40, 1'b0);
    // Random mid-range settings.
    load_settings($urandom_range(1, 127), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(20000, 400000), $urandom_range(0, 200000));
    random_phase(170, 1'b1);

    wait_drained(2 * SETTLE_CYCLES);
    $display("Covered %0d input beats (directed table and random moves) under %0d settings",
             beats_in, settings_used + 1);
    $display("Checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("wheel_balance_move_controller_top test passed");
    end else begin
      $display("wheel_balance_move_controller_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wbm_pkg.sv
src/wbm_cfg_regs.sv
src/wbm_mult.sv
src/wheel_balance_move_controller_top.sv
tb/tb_wheel_balance_move_controller_top.sv
